// ===== rtl/plfas_pkg.sv =====
// Shared types, constants and helper functions of the pair cipher core.
`timescale 1ns / 1ps

package plfas_pkg;

  // Alphabet and key square geometry.
  localparam int ALPHA  = 26;
  localparam int SIDE   = 5;
  localparam int LTR_W  = 5;
  localparam int IDX_W  = $clog2(SIDE);
  localparam int SUM_W  = LTR_W + 1;
  localparam int PROD_W = 2 * LTR_W;
  localparam int ROW_W  = SIDE * LTR_W;

  // Pipeline depth from the input ports to the output register.
  localparam int STAGES = 6;

  // Reciprocal of 26 scaled by 2^15, rounded down so the quotient never overshoots.
  localparam int RECIP_26    = 1260;
  localparam int RECIP_W     = 11;
  localparam int RECIP_SHIFT = 15;

  // Letter codes with special handling in the square lookup.
  localparam logic [LTR_W-1:0] CODE_J = LTR_W'(9);
  localparam logic [LTR_W-1:0] CODE_I = LTR_W'(8);

  // Configuration register indexes.
  localparam int REG_W = 3;
  localparam logic [REG_W-1:0] REG_ROW0  = 3'd0;
  localparam logic [REG_W-1:0] REG_ROW1  = 3'd1;
  localparam logic [REG_W-1:0] REG_ROW2  = 3'd2;
  localparam logic [REG_W-1:0] REG_ROW3  = 3'd3;
  localparam logic [REG_W-1:0] REG_ROW4  = 3'd4;
  localparam logic [REG_W-1:0] REG_SHIFT = 3'd5;
  localparam logic [REG_W-1:0] REG_MULT  = 3'd6;
  localparam logic [REG_W-1:0] REG_ADD   = 3'd7;

  typedef logic [SIDE-1:0][LTR_W-1:0] row_t;
  typedef row_t [SIDE-1:0] square_t;

  // Reset key square: a..z without j, row 0 lowest.
  localparam square_t SQUARE_RESET = {
    25'd27025109, 25'd21613104, 25'd16201099, 25'd10755269, 25'd4294688
  };
  localparam logic [LTR_W-1:0] SHIFT_RESET = LTR_W'(0);
  localparam logic [LTR_W-1:0] MULT_RESET  = LTR_W'(11);
  localparam logic [LTR_W-1:0] ADD_RESET   = LTR_W'(15);

  // Key material as the lanes see it, with reduced copies prepared once.
  typedef struct packed {
    square_t          square;
    logic [LTR_W-1:0] mult;
    logic [LTR_W-1:0] add;
    logic [LTR_W-1:0] add_mod;
    logic [LTR_W-1:0] shift_mod;
    logic [LTR_W-1:0] inv;
  } key_t;

  // Position of a letter in the square.
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } loc_t;

  // Stage loads and actions for an input lane.
  typedef struct packed {
    logic ld_prod;
    logic ld_letter;
    logic ld_loc;
    logic act_in;
    logic act_prod;
  } pre_ctl_t;

  // Stage loads and actions for an output lane.
  typedef struct packed {
    logic ld_mac;
    logic ld_out;
    logic act_in;
    logic act_mac;
  } post_ctl_t;

  // Reduce a 5-bit code modulo 26.
  function automatic logic [LTR_W-1:0] mod26_small(input logic [LTR_W-1:0] x);
    return (x >= LTR_W'(ALPHA)) ? x - LTR_W'(ALPHA) : x;
  endfunction

  // Reduce a product-wide value modulo 26 by reciprocal multiply and one correction.
  function automatic logic [LTR_W-1:0] mod26_wide(input logic [PROD_W-1:0] v);
    logic [PROD_W+RECIP_W-1:0] scaled;
    logic [PROD_W-1:0]         quo;
    logic [PROD_W-1:0]         rest;
    scaled = (PROD_W+RECIP_W)'(v) * (PROD_W+RECIP_W)'(RECIP_26);
    quo    = PROD_W'(scaled >> RECIP_SHIFT);
    rest   = v - PROD_W'(quo * PROD_W'(ALPHA));
    if (rest >= PROD_W'(ALPHA)) begin
      rest = rest - PROD_W'(ALPHA);
    end
    return rest[LTR_W-1:0];
  endfunction

  // Multiplicative inverse modulo 26; non-units map to zero.
  function automatic logic [LTR_W-1:0] inv_of(input logic [LTR_W-1:0] a);
    logic [LTR_W-1:0] r;
    case (a)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/plfas_pre_lane.sv =====
// Input lane: undoes shift and affine on decrypt, then finds the letter in the key square.
`timescale 1ns / 1ps

module plfas_pre_lane import plfas_pkg::*; (
  input  logic             clk,
  input  pre_ctl_t         ctl,
  input  key_t             key,
  input  logic [LTR_W-1:0] letter,
  output loc_t             loc
);

  logic [SUM_W-1:0]  diff_shift;
  logic [SUM_W-1:0]  diff_add;
  logic [LTR_W-1:0]  unshifted;
  logic [LTR_W-1:0]  unadded;
  logic [PROD_W-1:0] prod_next;
  logic [PROD_W-1:0] prod;
  logic [LTR_W-1:0]  letter_next;
  logic [LTR_W-1:0]  letter_q;
  logic [LTR_W-1:0]  probe;
  loc_t              loc_next;

  // Stage one: decrypt subtracts the shift and additive constant and scales by the inverse.
  always_comb begin
    diff_shift = SUM_W'(mod26_small(letter)) + SUM_W'(ALPHA) - SUM_W'(key.shift_mod);
    unshifted  = (diff_shift >= SUM_W'(ALPHA)) ? LTR_W'(diff_shift - SUM_W'(ALPHA))
                                               : diff_shift[LTR_W-1:0];
    diff_add   = SUM_W'(unshifted) + SUM_W'(ALPHA) - SUM_W'(key.add_mod);
    unadded    = (diff_add >= SUM_W'(ALPHA)) ? LTR_W'(diff_add - SUM_W'(ALPHA))
                                             : diff_add[LTR_W-1:0];
    prod_next  = ctl.act_in ? PROD_W'(unadded) * PROD_W'(key.inv) : PROD_W'(letter);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_prod) begin
      prod <= prod_next;
    end
  end

  // Stage two: reduce the decrypt product to a letter; encrypt passes the raw code.
  assign letter_next = ctl.act_prod ? mod26_wide(prod) : prod[LTR_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.ld_letter) begin
      letter_q <= letter_next;
    end
  end

  // Stage three: fold j to i and search the square; the last match wins, a miss gives the corner.
  always_comb begin
    probe    = (letter_q == CODE_J) ? CODE_I : letter_q;
    loc_next = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (key.square[r][c] == probe) begin
          loc_next.row = IDX_W'(r);
          loc_next.col = IDX_W'(c);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_loc) begin
      loc <= loc_next;
    end
  end

endmodule

// ===== rtl/plfas_merge.sv =====
// Merging stage: applies the row, column or rectangle rule to the two located letters.
`timescale 1ns / 1ps

module plfas_merge import plfas_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic             act,
  input  square_t          square,
  input  loc_t             loc_a,
  input  loc_t             loc_b,
  output logic [LTR_W-1:0] first_q,
  output logic [LTR_W-1:0] second_q
);

  logic [LTR_W-1:0] first_next;
  logic [LTR_W-1:0] second_next;

  // Step one place with wraparound: forward on encrypt, backward on decrypt.
  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx,
                                                input logic back);
    logic [IDX_W-1:0] r;
    if (back) begin
      r = (idx == '0) ? IDX_W'(SIDE - 1) : idx - IDX_W'(1);
    end else begin
      r = (idx == IDX_W'(SIDE - 1)) ? '0 : idx + IDX_W'(1);
    end
    return r;
  endfunction

  // Pick the two replacement letters.
  always_comb begin
    if (loc_a.row == loc_b.row) begin
      first_next  = square[loc_a.row][step_idx(loc_a.col, act)];
      second_next = square[loc_b.row][step_idx(loc_b.col, act)];
    end else if (loc_a.col == loc_b.col) begin
      first_next  = square[step_idx(loc_a.row, act)][loc_a.col];
      second_next = square[step_idx(loc_b.row, act)][loc_b.col];
    end else begin
      first_next  = square[loc_a.row][loc_b.col];
      second_next = square[loc_b.row][loc_a.col];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_q  <= first_next;
      second_q <= second_next;
    end
  end

endmodule

// ===== rtl/plfas_post_lane.sv =====
// Output lane: applies the affine map and the shift on encrypt; decrypt passes the letter.
`timescale 1ns / 1ps

module plfas_post_lane import plfas_pkg::*; (
  input  logic             clk,
  input  post_ctl_t        ctl,
  input  key_t             key,
  input  logic [LTR_W-1:0] letter,
  output logic [LTR_W-1:0] result
);

  logic [PROD_W-1:0] mac_next;
  logic [PROD_W-1:0] mac;
  logic [SUM_W-1:0]  shifted;
  logic [LTR_W-1:0]  result_next;

  // Stage five: on encrypt, multiply by a and add b; decrypt passes the letter.
  assign mac_next = ctl.act_in ? PROD_W'(letter)
                               : PROD_W'(key.mult) * PROD_W'(letter) + PROD_W'(key.add);

  always_ff @(posedge clk) begin
    if (ctl.ld_mac) begin
      mac <= mac_next;
    end
  end

  // Stage six: on encrypt, reduce modulo 26 and add the shift with one wrap; decrypt passes the letter.
  always_comb begin
    shifted = SUM_W'(mod26_wide(mac)) + SUM_W'(key.shift_mod);
    if (shifted >= SUM_W'(ALPHA)) begin
      shifted = shifted - SUM_W'(ALPHA);
    end
    result_next = ctl.act_mac ? mac[LTR_W-1:0] : shifted[LTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/playfair_affine_shift_cipher_core.sv =====
// Top level of the Playfair, affine and shift pair cipher core.
// The core takes one letter pair per clock while in_stall is low and returns one pair per
// item, in order, from a six-stage pipeline (inverse-affine product, reduction, square
// search, pair rule, affine product, reduction and shift) with one lane per letter and a
// merge stage between. Each stage holds its item while the next holds, so bubbles close up
// and up to six items, the stalled one at the output included, are held before the input
// stalls. Configuration writes take effect on the next cycle and should be made only while
// the pipeline is empty; there is no clearing pass after reset.
`timescale 1ns / 1ps

module playfair_affine_shift_cipher_core import plfas_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [REG_W-1:0] cfg_index,
  input  logic [ROW_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             action,
  input  logic [LTR_W-1:0] first_letter,
  input  logic [LTR_W-1:0] second_letter,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [LTR_W-1:0] first_out,
  output logic [LTR_W-1:0] second_out
);

  square_t          square;
  logic [LTR_W-1:0] shift_key;
  logic [LTR_W-1:0] affine_mult;
  logic [LTR_W-1:0] affine_add;
  key_t             key;

  logic [STAGES:1]   vld;
  logic [STAGES+1:1] adv;
  logic [STAGES-1:1] act_s;

  pre_ctl_t         pre_ctl;
  post_ctl_t        post_ctl;
  loc_t             loc_a;
  loc_t             loc_b;
  logic [LTR_W-1:0] pf_first;
  logic [LTR_W-1:0] pf_second;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      square      <= SQUARE_RESET;
      shift_key   <= SHIFT_RESET;
      affine_mult <= MULT_RESET;
      affine_add  <= ADD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3, REG_ROW4: begin
          square[cfg_index[IDX_W-1:0]] <= cfg_data;
        end
        REG_SHIFT: shift_key   <= cfg_data[LTR_W-1:0];
        REG_MULT:  affine_mult <= cfg_data[LTR_W-1:0];
        REG_ADD:   affine_add  <= cfg_data[LTR_W-1:0];
        default: ;
      endcase
    end
  end

  // Key material with the reductions the lanes need.
  always_comb begin
    key.square    = square;
    key.mult      = affine_mult;
    key.add       = affine_add;
    key.add_mod   = mod26_small(affine_add);
    key.shift_mod = mod26_small(shift_key);
    key.inv       = inv_of(mod26_small(affine_mult));
  end

  // A stage may load when it is empty or its item moves on in the same cycle.
  always_comb begin
    adv[STAGES+1] = !out_stall;
    for (int k = STAGES; k >= 1; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_stall  = !adv[1];
  assign out_valid = vld[STAGES];

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= (k == 1) ? in_valid : vld[k-1];
        end
      end
    end
  end

  // Action of each item travels beside it.
  always_ff @(posedge clk) begin
    for (int k = 1; k < STAGES; k++) begin
      if (adv[k]) begin
        act_s[k] <= (k == 1) ? action : act_s[k-1];
      end
    end
  end

  // Lane controls.
  always_comb begin
    pre_ctl.ld_prod   = adv[1];
    pre_ctl.ld_letter = adv[2];
    pre_ctl.ld_loc    = adv[3];
    pre_ctl.act_in    = action;
    pre_ctl.act_prod  = act_s[1];
    post_ctl.ld_mac   = adv[5];
    post_ctl.ld_out   = adv[6];
    post_ctl.act_in   = act_s[4];
    post_ctl.act_mac  = act_s[5];
  end

  plfas_pre_lane u_pre_first (
    .clk    (clk),
    .ctl    (pre_ctl),
    .key    (key),
    .letter (first_letter),
    .loc    (loc_a)
  );

  plfas_pre_lane u_pre_second (
    .clk    (clk),
    .ctl    (pre_ctl),
    .key    (key),
    .letter (second_letter),
    .loc    (loc_b)
  );

  plfas_merge u_merge (
    .clk      (clk),
    .load     (adv[4]),
    .act      (act_s[3]),
    .square   (square),
    .loc_a    (loc_a),
    .loc_b    (loc_b),
    .first_q  (pf_first),
    .second_q (pf_second)
  );

  plfas_post_lane u_post_first (
    .clk    (clk),
    .ctl    (post_ctl),
    .key    (key),
    .letter (pf_first),
    .result (first_out)
  );

  plfas_post_lane u_post_second (
    .clk    (clk),
    .ctl    (post_ctl),
    .key    (key),
    .letter (pf_second),
    .result (second_out)
  );

endmodule

// ===== rtl/plfas_checker.sv =====
// Port-level checks of the pair cipher core, bound to the top level.
`timescale 1ns / 1ps

module plfas_checker import plfas_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [LTR_W-1:0] first_out,
  input logic [LTR_W-1:0] second_out
);

  // Reset empties the pipeline, so no item is offered on the next cycle.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result item offered right after reset");

  // The input only backs up when the output holds an item that is being stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output can move");

  // A stalled result item stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result item withdrawn");

  // A stalled result item keeps its letters.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> ($stable(first_out) && $stable(second_out)))
    else $error("stalled result item changed");

endmodule

bind playfair_affine_shift_cipher_core plfas_checker u_plfas_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .first_out  (first_out),
  .second_out (second_out)
);
